[rtl/kear_pkg.sv]
// Shared types and constants for the key edge and auto repeat tracker.
package kear_pkg;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned IN_TDATA_W = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CNT_W-1:0] HOLD_MAX = 8'hFF;
  localparam logic [CNT_W-1:0] DELAY_RESET = 8'd20;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 8'd7;

  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD = 8'd1;

  typedef struct packed {
    logic             prev_level;
    logic [CNT_W-1:0] hold_count;
    logic [CNT_W-1:0] repeat_phase;
  } entry_t;

  typedef struct packed {
    logic             auto_repeat;
    logic             released_edge;
    logic             pressed_edge;
    logic             held;
    logic [KEY_W-1:0] key_number;
  } result_t;

endpackage

[rtl/kear_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kear_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kear_update.sv]
// Per-key entry update: edge flags, saturating hold count, repeat phase.
module kear_update (
  input  kear_pkg::entry_t              cur,
  input  logic                          level,
  input  logic                          in_range,
  input  logic [kear_pkg::CNT_W-1:0]    repeat_delay,
  input  logic [kear_pkg::CNT_W-1:0]    repeat_period,
  input  logic [kear_pkg::KEY_W-1:0]    key,
  output kear_pkg::entry_t              nxt,
  output kear_pkg::result_t             res
);

  logic [kear_pkg::CNT_W-1:0] cnt;
  logic [kear_pkg::CNT_W:0]   ph_inc;
  logic [kear_pkg::CNT_W-1:0] ph;

  always_comb begin
    cnt = (cur.hold_count == kear_pkg::HOLD_MAX) ? kear_pkg::HOLD_MAX
                                                  : cur.hold_count + 8'd1;
    ph_inc = {1'b0, cur.repeat_phase} + 9'd1;
    ph = (ph_inc >= {1'b0, repeat_period}) ? '0 : ph_inc[kear_pkg::CNT_W-1:0];

    nxt.prev_level = level;
    nxt.hold_count = level ? cnt : '0;
    nxt.repeat_phase = level ? ph : '0;

    res.key_number = key;
    res.held = level;
    res.pressed_edge = in_range & level & ~cur.prev_level;
    res.released_edge = in_range & ~level & cur.prev_level;
    res.auto_repeat = in_range & level & (cnt >= repeat_delay) & (ph == '0);
  end

endmodule

[rtl/kear_outq.sv]
// Small result queue between the update stage and the output beat.
module kear_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kear_pkg::result_t push_data,
  input  logic              pop,
  output logic              not_empty,
  output kear_pkg::result_t head,
  output logic [2:0]        count
);

  localparam int unsigned DEPTH = 4;

  kear_pkg::result_t buffer [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;

  assign not_empty = (count != 3'd0);
  assign head = buffer[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buffer[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

[rtl/key_edge_auto_repeat_tracker.sv]
// Key edge detector with auto repeat: per-key state held in a RAM with registered read.
// Path: an input beat is registered with its RAM read, then updated and pushed into
//   the result queue, which offers it at the earliest on the cycle after the update.
// Throughput: one key sample per cycle while s_tready is high; RAM read at accept,
//   write-back next cycle, last write forwarded to a back-to-back same-key sample.
// Reset: clears control state, then sweeps every RAM entry to zero with s_tready
//   low; configuration writes are taken throughout.
module key_edge_auto_repeat_tracker #(
  parameter int unsigned KEYS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [kear_pkg::IN_TDATA_W-1:0]       s_tdata,   // key_index[7:0], pressed[8]
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [kear_pkg::OUT_TDATA_W-1:0]      m_tdata,   // key_number[7:0], held[8],
                                                           // pressed_edge[9],
                                                           // released_edge[10],
                                                           // auto_repeat[11]
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [kear_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [kear_pkg::CNT_W-1:0]            cfg_data
);

  localparam int unsigned AW = $clog2(KEYS);
  localparam int unsigned EW = $bits(kear_pkg::entry_t);

  logic [kear_pkg::CNT_W-1:0] repeat_delay;
  logic [kear_pkg::CNT_W-1:0] repeat_period;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic                       s1_valid;
  logic [kear_pkg::KEY_W-1:0] s1_key;
  logic                       s1_level;
  logic                       s1_in_range;

  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  kear_pkg::entry_t fwd_data;

  logic                       in_beat;
  logic [kear_pkg::KEY_W-1:0] in_key;
  logic [AW-1:0]              s1_addr;
  logic [EW-1:0]              rd_raw;
  kear_pkg::entry_t           cur;
  kear_pkg::entry_t           nxt;
  kear_pkg::result_t          res;
  kear_pkg::result_t          q_head;
  logic [2:0]                 q_count;
  logic                       s1_write;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [EW-1:0]              ram_wdata;

  assign cfg_ready = 1'b1;
  assign in_key = s_tdata[kear_pkg::KEY_W-1:0];
  assign in_beat = s_tvalid & s_tready;
  assign s_tready = ~clearing & (({2'b0, s1_valid} + q_count) < 3'd3);
  assign s1_addr = AW'(s1_key);
  assign s1_write = s1_valid & s1_in_range;

  assign cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : kear_pkg::entry_t'(rd_raw);

  assign ram_we = clearing | s1_write;
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : nxt;

  kear_ram #(
    .WIDTH(EW),
    .DEPTH(KEYS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(AW'(in_key)),
    .rdata(rd_raw)
  );

  kear_update u_update (
    .cur          (cur),
    .level        (s1_level),
    .in_range     (s1_in_range),
    .repeat_delay (repeat_delay),
    .repeat_period(repeat_period),
    .key          (s1_key),
    .nxt          (nxt),
    .res          (res)
  );

  kear_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_data(res),
    .pop      (m_tvalid & m_tready),
    .not_empty(m_tvalid),
    .head     (q_head),
    .count    (q_count)
  );

  assign m_tdata = {4'b0, q_head};

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay <= kear_pkg::DELAY_RESET;
      repeat_period <= kear_pkg::PERIOD_RESET;
    end else if (cfg_valid & cfg_ready) begin
      case (cfg_index)
        kear_pkg::REG_REPEAT_DELAY:  repeat_delay <= cfg_data;
        kear_pkg::REG_REPEAT_PERIOD: repeat_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(KEYS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid <= in_beat;
      fwd_valid <= s1_write;
    end
  end

  always_ff @(posedge clk) begin
    s1_key <= in_key;
    s1_level <= s_tdata[kear_pkg::KEY_W];
    s1_in_range <= (32'(in_key) < KEYS);
    fwd_addr <= s1_addr;
    fwd_data <= nxt;
  end

endmodule

[rtl/kear_checker.sv]
// Port-level checks for the key edge tracker, bound to the top level.
module kear_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [kear_pkg::OUT_TDATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed while stalled");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("input taken or result offered right after reset");

  a_edges_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[9] && m_tdata[10]))
    else $error("rise and fall flagged together");

  a_edge_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[9] || m_tdata[8]) && (!m_tdata[10] || !m_tdata[8]))
    else $error("edge flag disagrees with level");

  a_repeat_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[8])
    else $error("auto repeat on a released key");

endmodule

bind key_edge_auto_repeat_tracker kear_checker u_kear_checker (.*);
